// ----- sv/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// Types and constants shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_NEG  = 3'd4;
  localparam logic [2:0] OP_NORM = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [4:0] {
    C_NONE, C_CAPTURE,
    C_LXG, C_LXN, C_LXD, C_LYG, C_LYN, C_LYD, C_PREP,
    C_MG1, C_MG2, C_MXN, C_MYD, C_MYN, C_MXD, C_MNUM, C_MDEN,
    C_AG, C_AU, C_AV, C_AA, C_AB, C_ACOMB, C_ADR, C_ADG2, C_ADQ, C_AY, C_ADEN,
    C_UNARY, C_EMIT, C_ERR
  } step_t;

  typedef struct packed {
    step_t step;
    logic  start;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic xd_zero;
    logic yd_zero;
    logic xn_zero;
    logic yn_zero;
    logic t_zero;
    logic binary;
    logic op_mul;
    logic op_div;
  } sts_t;

endpackage

// ----- sv/rational_arithmetic_unit_top.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Exact add, subtract, multiply, divide, negate and normalize on fractions.
//
// One input item holds the operation and two fractions of signed 64-bit
// numerator and denominator; it is taken when in_valid is high and in_stall
// low. One result item comes back per input: reduced numerator, positive
// denominator and a status, shown while out_valid is high and taken when
// out_stall is low. The unit works on one item at a time and holds in_stall
// high from acceptance until the result is taken.
// The time to a result depends on the data: every gcd takes one binary step
// per cycle until one operand is zero. A zero denominator goes from the check
// state through the error state to the result without any unit step.
// The next item can be taken in the cycle after the result is taken.
// While the receiver stalls, the result stays on the outputs unchanged.
// Reset returns the sequencer to idle; no result is pending afterwards.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top #(
  parameter int WORD_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         operation,
  input  logic signed [63:0] first_numerator,
  input  logic signed [63:0] first_denominator,
  input  logic signed [63:0] second_numerator,
  input  logic signed [63:0] second_denominator,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] result_numerator,
  output logic [62:0]        result_denominator,
  output logic [1:0]         status
);
  import rau_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rau_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .operation(operation),
    .first_numerator(first_numerator), .first_denominator(first_denominator),
    .second_numerator(second_numerator), .second_denominator(second_denominator),
    .result_numerator(result_numerator), .result_denominator(result_denominator),
    .status(status)
  );
endmodule

// ----- sv/rau_gcd.sv -----
// ----------------------------------------------------------------------------
// rau_gcd
// Binary gcd of two 64-bit magnitudes, one step per cycle.
// ----------------------------------------------------------------------------
module rau_gcd (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] res
);
  logic [63:0] ra;
  logic [63:0] rb;
  logic [5:0]  k;
  logic        busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ra   <= a;
        rb   <= b;
        k    <= 6'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (ra == 64'd0) begin
          res  <= rb << k;
          busy <= 1'b0;
          done <= 1'b1;
        end else if (rb == 64'd0) begin
          res  <= ra << k;
          busy <= 1'b0;
          done <= 1'b1;
        end else if (!ra[0] && !rb[0]) begin
          ra <= ra >> 1;
          rb <= rb >> 1;
          k  <= k + 6'd1;
        end else if (!ra[0]) begin
          ra <= ra >> 1;
        end else if (!rb[0]) begin
          rb <= rb >> 1;
        end else if (ra >= rb) begin
          ra <= ra - rb;
        end else begin
          rb <= rb - ra;
        end
      end
    end
  end
endmodule

// ----- sv/rau_div.sv -----
// ----------------------------------------------------------------------------
// rau_div
// Restoring divider, 128-bit dividend by 64-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module rau_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] dividend,
  input  logic [63:0]  divisor,
  output logic         done,
  output logic [127:0] quo,
  output logic [63:0]  rem
);
  logic [127:0] n;
  logic [63:0]  d;
  logic [7:0]   cnt;
  logic         busy;
  logic [64:0]  r2;
  logic [64:0]  diff;
  logic         ge;

  assign r2   = {rem, n[127]};
  assign diff = r2 - {1'b0, d};
  assign ge   = r2 >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        d    <= divisor;
        rem  <= 64'd0;
        quo  <= 128'd0;
        busy <= 1'b1;
        if (dividend[127:64] == 64'd0) begin
          n   <= {dividend[63:0], 64'd0};
          cnt <= 8'd64;
        end else begin
          n   <= dividend;
          cnt <= 8'd128;
        end
      end else if (busy) begin
        n   <= n << 1;
        quo <= {quo[126:0], ge};
        rem <= ge ? diff[63:0] : r2[63:0];
        cnt <= cnt - 8'd1;
        if (cnt == 8'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- sv/rau_mul.sv -----
// ----------------------------------------------------------------------------
// rau_mul
// Shift-add multiplier, 64 by 64 bits to 128 bits, one bit per cycle.
// ----------------------------------------------------------------------------
module rau_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);
  logic [127:0] pa;
  logic [63:0]  pb;
  logic [6:0]   cnt;
  logic         busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        pa   <= {64'd0, a};
        pb   <= b;
        prod <= 128'd0;
        cnt  <= 7'd64;
        busy <= 1'b1;
      end else if (busy) begin
        if (pb[0]) prod <= prod + pa;
        pa  <= pa << 1;
        pb  <= pb >> 1;
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- sv/rau_datapath.sv -----
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, shared gcd, divide and multiply units, result register.
// ----------------------------------------------------------------------------
module rau_datapath #(
  parameter int WORD_BITS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  rau_pkg::cmd_t       cmd,
  output rau_pkg::sts_t       sts,
  input  logic [2:0]          operation,
  input  logic signed [63:0]  first_numerator,
  input  logic signed [63:0]  first_denominator,
  input  logic signed [63:0]  second_numerator,
  input  logic signed [63:0]  second_denominator,
  output logic signed [63:0]  result_numerator,
  output logic [62:0]         result_denominator,
  output logic [1:0]          status
);
  import rau_pkg::*;

  localparam logic [63:0] LIM    = 64'd1 << (WORD_BITS - 1);
  localparam logic [63:0] LIM_M1 = LIM - 64'd1;

  logic [2:0]   op_q;
  logic [63:0]  xn, xd, yn, yd, g, g2, u, v;
  logic         xneg, yneg, neg;
  logic [127:0] wa, wb, wn, wd;

  logic         gcd_go, div_go, mul_go;
  logic [63:0]  gcd_a, gcd_b, gcd_res;
  logic [127:0] div_n, div_q;
  logic [63:0]  div_d, div_r;
  logic [63:0]  mul_a, mul_b;
  logic [127:0] mul_p;
  logic         gcd_done, div_done, mul_done;

  logic [127:0] t;
  logic         t_neg;
  logic [63:0]  em_num;
  logic [62:0]  em_den;
  logic [1:0]   em_st;
  logic         ovf;

  function automatic logic [63:0] mag(input logic [63:0] x);
    mag = x[63] ? (~x + 64'd1) : x;
  endfunction

  always_comb begin
    gcd_go = 1'b0;
    div_go = 1'b0;
    mul_go = 1'b0;
    gcd_a  = xn;
    gcd_b  = xd;
    div_n  = {64'd0, xn};
    div_d  = g;
    mul_a  = xn;
    mul_b  = yn;
    case (cmd.step)
      C_LXG:  gcd_go = 1'b1;
      C_LYG:  begin gcd_go = 1'b1; gcd_a = yn; gcd_b = yd; end
      C_MG1:  begin gcd_go = 1'b1; gcd_a = xn; gcd_b = yd; end
      C_MG2:  begin gcd_go = 1'b1; gcd_a = yn; gcd_b = xd; end
      C_AG:   begin gcd_go = 1'b1; gcd_a = xd; gcd_b = yd; end
      C_ADG2: begin gcd_go = 1'b1; gcd_a = g;  gcd_b = g2; end
      C_LXN:  div_go = 1'b1;
      C_LXD:  begin div_go = 1'b1; div_n = {64'd0, xd}; end
      C_LYN:  begin div_go = 1'b1; div_n = {64'd0, yn}; end
      C_LYD:  begin div_go = 1'b1; div_n = {64'd0, yd}; end
      C_MXN:  div_go = 1'b1;
      C_MYD:  begin div_go = 1'b1; div_n = {64'd0, yd}; end
      C_MYN:  begin div_go = 1'b1; div_n = {64'd0, yn}; div_d = g2; end
      C_MXD:  begin div_go = 1'b1; div_n = {64'd0, xd}; div_d = g2; end
      C_AU:   begin div_go = 1'b1; div_n = {64'd0, yd}; end
      C_AV:   begin div_go = 1'b1; div_n = {64'd0, xd}; end
      C_ADR:  begin div_go = 1'b1; div_n = wn; end
      C_ADQ:  begin div_go = 1'b1; div_n = wn; div_d = g2; end
      C_AY:   begin div_go = 1'b1; div_n = {64'd0, yd}; div_d = g2; end
      C_MNUM: mul_go = 1'b1;
      C_MDEN: begin mul_go = 1'b1; mul_a = xd; mul_b = yd; end
      C_AA:   begin mul_go = 1'b1; mul_a = xn; mul_b = u; end
      C_AB:   begin mul_go = 1'b1; mul_a = yn; mul_b = v; end
      C_ADEN: begin mul_go = 1'b1; mul_a = v;  mul_b = u; end
      default: ;
    endcase
  end

  rau_gcd u_gcd (
    .clk(clk), .rst(rst), .start(cmd.start & gcd_go), .a(gcd_a), .b(gcd_b),
    .done(gcd_done), .res(gcd_res)
  );

  rau_div u_div (
    .clk(clk), .rst(rst), .start(cmd.start & div_go), .dividend(div_n),
    .divisor(div_d), .done(div_done), .quo(div_q), .rem(div_r)
  );

  rau_mul u_mul (
    .clk(clk), .rst(rst), .start(cmd.start & mul_go), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  // signed sum of the two scaled numerators
  always_comb begin
    if (xneg == yneg) begin
      t     = wa + wb;
      t_neg = xneg;
    end else if (wa >= wb) begin
      t     = wa - wb;
      t_neg = xneg;
    end else begin
      t     = wb - wa;
      t_neg = yneg;
    end
  end

  always_comb begin
    ovf = (wn[127:64] != 64'd0) || (wd[127:64] != 64'd0) || (wd[63:0] > LIM_M1) ||
          (wn[63:0] > (neg ? LIM : LIM_M1));
    if (wn == 128'd0) begin
      em_num = 64'd0;
      em_den = 63'd1;
      em_st  = ST_OK;
    end else if (ovf) begin
      em_num = 64'd0;
      em_den = 63'd1;
      em_st  = ST_OVERFLOW;
    end else begin
      em_num = neg ? (~wn[63:0] + 64'd1) : wn[63:0];
      em_den = wd[62:0];
      em_st  = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      case (cmd.step)
        C_CAPTURE: begin
          op_q <= operation;
          xn   <= mag(first_numerator);
          xd   <= mag(first_denominator);
          yn   <= mag(second_numerator);
          yd   <= mag(second_denominator);
          xneg <= first_numerator[63] ^ first_denominator[63];
          yneg <= second_numerator[63] ^ second_denominator[63];
        end
        C_PREP: begin
          if (op_q == OP_SUB && yn != 64'd0) yneg <= ~yneg;
          if (op_q == OP_DIV) begin
            yn <= yd;
            yd <= yn;
          end
          neg <= xneg ^ yneg;
          wn  <= 128'd0;
        end
        C_ACOMB: begin
          wn  <= t;
          neg <= t_neg;
        end
        C_UNARY: begin
          wn  <= {64'd0, xn};
          wd  <= {64'd0, xd};
          neg <= xneg ^ (op_q == OP_NEG && xn != 64'd0);
        end
        C_EMIT: begin
          result_numerator   <= em_num;
          result_denominator <= em_den;
          status             <= em_st;
        end
        C_ERR: begin
          result_numerator   <= 64'd0;
          result_denominator <= 63'd1;
          status             <= ST_ZERO_DEN;
        end
        default: ;
      endcase
    end
    if (gcd_done) begin
      case (cmd.step)
        C_MG2, C_ADG2: g2 <= gcd_res;
        default:       g  <= gcd_res;
      endcase
    end
    if (div_done) begin
      case (cmd.step)
        C_LXN: begin
          xn <= div_q[63:0];
          if (div_q[63:0] == 64'd0) xneg <= 1'b0;
        end
        C_LYN: begin
          yn <= div_q[63:0];
          if (div_q[63:0] == 64'd0) yneg <= 1'b0;
        end
        C_LXD, C_MXD: xd <= div_q[63:0];
        C_LYD, C_MYD: yd <= div_q[63:0];
        C_MXN:        xn <= div_q[63:0];
        C_MYN:        yn <= div_q[63:0];
        C_AU, C_AY:   u  <= div_q[63:0];
        C_AV:         v  <= div_q[63:0];
        C_ADR:        g2 <= div_r;
        C_ADQ:        wn <= div_q;
        default: ;
      endcase
    end
    if (mul_done) begin
      case (cmd.step)
        C_MNUM:         wn <= mul_p;
        C_AA:           wa <= mul_p;
        C_AB:           wb <= mul_p;
        C_MDEN, C_ADEN: wd <= mul_p;
        default: ;
      endcase
    end
  end

  assign sts.done    = gcd_done | div_done | mul_done;
  assign sts.xd_zero = (xd == 64'd0);
  assign sts.yd_zero = (yd == 64'd0);
  assign sts.xn_zero = (xn == 64'd0);
  assign sts.yn_zero = (yn == 64'd0);
  assign sts.t_zero  = (t == 128'd0);
  assign sts.binary  = (op_q <= OP_DIV);
  assign sts.op_mul  = (op_q == OP_MUL);
  assign sts.op_div  = (op_q == OP_DIV);
endmodule

// ----- sv/rau_ctrl.sv -----
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer that walks the datapath through load, reduce and emit steps.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output rau_pkg::cmd_t  cmd,
  input  rau_pkg::sts_t  sts
);
  import rau_pkg::*;

  typedef enum logic [31:0] {
    S_IDLE  = 32'h0000_0001, S_CHK   = 32'h0000_0002, S_LXG  = 32'h0000_0004,
    S_LXN   = 32'h0000_0008, S_LXD   = 32'h0000_0010, S_LYG  = 32'h0000_0020,
    S_LYN   = 32'h0000_0040, S_LYD   = 32'h0000_0080, S_PREP = 32'h0000_0100,
    S_MG1   = 32'h0000_0200, S_MG2   = 32'h0000_0400, S_MXN  = 32'h0000_0800,
    S_MYD   = 32'h0000_1000, S_MYN   = 32'h0000_2000, S_MXD  = 32'h0000_4000,
    S_MNUM  = 32'h0000_8000, S_MDEN  = 32'h0001_0000, S_AG   = 32'h0002_0000,
    S_AU    = 32'h0004_0000, S_AV    = 32'h0008_0000, S_AA   = 32'h0010_0000,
    S_AB    = 32'h0020_0000, S_ACOMB = 32'h0040_0000, S_ADR  = 32'h0080_0000,
    S_ADG2  = 32'h0100_0000, S_ADQ   = 32'h0200_0000, S_AY   = 32'h0400_0000,
    S_ADEN  = 32'h0800_0000, S_UNARY = 32'h1000_0000, S_EMIT = 32'h2000_0000,
    S_ERR   = 32'h4000_0000, S_OUT   = 32'h8000_0000
  } state_t;

  state_t state, state_next, after_unit;
  logic   waiting, waiting_next, unit;

  always_comb begin
    state_next   = state;
    waiting_next = waiting;
    after_unit   = state;
    unit         = 1'b0;
    cmd.step     = C_NONE;
    cmd.start    = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.step  = C_CAPTURE;
        cmd.start = in_valid;
        if (in_valid) state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.xd_zero || (sts.binary && sts.yd_zero)) state_next = S_ERR;
        else state_next = S_LXG;
      end
      S_LXG:  begin cmd.step = C_LXG;  unit = 1'b1; after_unit = S_LXN; end
      S_LXN:  begin cmd.step = C_LXN;  unit = 1'b1; after_unit = S_LXD; end
      S_LXD:  begin
        cmd.step   = C_LXD;
        unit       = 1'b1;
        after_unit = sts.binary ? S_LYG : S_UNARY;
      end
      S_LYG:  begin cmd.step = C_LYG;  unit = 1'b1; after_unit = S_LYN; end
      S_LYN:  begin cmd.step = C_LYN;  unit = 1'b1; after_unit = S_LYD; end
      S_LYD:  begin cmd.step = C_LYD;  unit = 1'b1; after_unit = S_PREP; end
      S_PREP: begin
        cmd.step  = C_PREP;
        cmd.start = 1'b1;
        if (sts.op_div && sts.yn_zero) state_next = S_ERR;
        else if ((sts.op_mul || sts.op_div) && (sts.xn_zero || sts.yn_zero))
          state_next = S_EMIT;
        else if (sts.op_mul || sts.op_div) state_next = S_MG1;
        else state_next = S_AG;
      end
      S_MG1:  begin cmd.step = C_MG1;  unit = 1'b1; after_unit = S_MG2; end
      S_MG2:  begin cmd.step = C_MG2;  unit = 1'b1; after_unit = S_MXN; end
      S_MXN:  begin cmd.step = C_MXN;  unit = 1'b1; after_unit = S_MYD; end
      S_MYD:  begin cmd.step = C_MYD;  unit = 1'b1; after_unit = S_MYN; end
      S_MYN:  begin cmd.step = C_MYN;  unit = 1'b1; after_unit = S_MXD; end
      S_MXD:  begin cmd.step = C_MXD;  unit = 1'b1; after_unit = S_MNUM; end
      S_MNUM: begin cmd.step = C_MNUM; unit = 1'b1; after_unit = S_MDEN; end
      S_MDEN: begin cmd.step = C_MDEN; unit = 1'b1; after_unit = S_EMIT; end
      S_AG:   begin cmd.step = C_AG;   unit = 1'b1; after_unit = S_AU; end
      S_AU:   begin cmd.step = C_AU;   unit = 1'b1; after_unit = S_AV; end
      S_AV:   begin cmd.step = C_AV;   unit = 1'b1; after_unit = S_AA; end
      S_AA:   begin cmd.step = C_AA;   unit = 1'b1; after_unit = S_AB; end
      S_AB:   begin cmd.step = C_AB;   unit = 1'b1; after_unit = S_ACOMB; end
      S_ACOMB: begin
        cmd.step   = C_ACOMB;
        cmd.start  = 1'b1;
        state_next = sts.t_zero ? S_EMIT : S_ADR;
      end
      S_ADR:  begin cmd.step = C_ADR;  unit = 1'b1; after_unit = S_ADG2; end
      S_ADG2: begin cmd.step = C_ADG2; unit = 1'b1; after_unit = S_ADQ; end
      S_ADQ:  begin cmd.step = C_ADQ;  unit = 1'b1; after_unit = S_AY; end
      S_AY:   begin cmd.step = C_AY;   unit = 1'b1; after_unit = S_ADEN; end
      S_ADEN: begin cmd.step = C_ADEN; unit = 1'b1; after_unit = S_EMIT; end
      S_UNARY: begin
        cmd.step   = C_UNARY;
        cmd.start  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.step   = C_EMIT;
        cmd.start  = 1'b1;
        state_next = S_OUT;
      end
      S_ERR: begin
        cmd.step   = C_ERR;
        cmd.start  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (unit) begin
      cmd.start    = !waiting;
      waiting_next = 1'b1;
      if (waiting && sts.done) begin
        waiting_next = 1'b0;
        state_next   = after_unit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      waiting <= 1'b0;
    end else begin
      state   <= state_next;
      waiting <= waiting_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
endmodule

// ----- sv/rau_checker.sv -----
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks on the rational arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module rau_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [63:0] result_numerator,
  input logic [62:0]        result_denominator,
  input logic [1:0]         status
);
  import rau_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(result_numerator) &&
      $stable(result_denominator) && $stable(status))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall && !out_valid)
    else $error("second item taken or early result");

  a_no_input_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  a_error_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |->
      result_numerator == 64'sd0 && result_denominator == 63'd1)
    else $error("error result not 0/1");
endmodule

bind rational_arithmetic_unit_top rau_checker u_chk (.*);
